// ----- hw/rtl/afc_pkg.sv -----
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants for the AABB frustum cull block.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int COEF_WIDTH      = 16;
    localparam int NUM_PLANES      = 6;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int CFG_DATA_WIDTH  = 4 * COEF_WIDTH;
    localparam int LOC_WIDTH       = 2;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_PLANE_RIGHT  = 3'd0,
        REG_PLANE_LEFT   = 3'd1,
        REG_PLANE_BOTTOM = 3'd2,
        REG_PLANE_TOP    = 3'd3,
        REG_PLANE_FAR    = 3'd4,
        REG_PLANE_NEAR   = 3'd5
    } plane_index_t;

    typedef enum logic [LOC_WIDTH-1:0] {
        LOC_OUTSIDE = 2'd0,
        LOC_INSIDE  = 2'd1,
        LOC_PARTIAL = 2'd2
    } location_t;

    // a in the low 16 bits, d in the high 16 bits
    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] d;
        logic signed [COEF_WIDTH-1:0] c;
        logic signed [COEF_WIDTH-1:0] b;
        logic signed [COEF_WIDTH-1:0] a;
    } plane_t;

    typedef struct packed {
        logic no_pos;
        logic all_pos;
    } plane_flags_t;

endpackage

// ----- hw/rtl/aabb_frustum_cull.sv -----
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// Classifies an axis-aligned box against six frustum planes.
// ----------------------------------------------------------------------------
// Registers: input, per-plane product, sum and flags, then the result.
// Throughput: one box per cycle unless stalled, from the single-pass pipeline.
// Backpressure stalls the whole pipeline only while the output word is held.
// Reset: synchronous active-low aresetn clears the pipeline valids and all
// plane registers to zero (every box then reads fully outside).
module aabb_frustum_cull #(
    parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_WIDTH-1:0]        s_min_x,
    input  logic signed [COORD_WIDTH-1:0]        s_min_y,
    input  logic signed [COORD_WIDTH-1:0]        s_min_z,
    input  logic signed [COORD_WIDTH-1:0]        s_max_x,
    input  logic signed [COORD_WIDTH-1:0]        s_max_y,
    input  logic signed [COORD_WIDTH-1:0]        s_max_z,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [afc_pkg::LOC_WIDTH-1:0]        m_location,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [afc_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [afc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    afc_pkg::plane_t       planes [afc_pkg::NUM_PLANES];
    afc_pkg::plane_flags_t flags  [afc_pkg::NUM_PLANES];

    logic                          en;
    logic [3:0]                    vld_reg;
    logic [3:0]                    vld_next;
    logic signed [COORD_WIDTH-1:0] lo_x_reg, lo_y_reg, lo_z_reg;
    logic signed [COORD_WIDTH-1:0] hi_x_reg, hi_y_reg, hi_z_reg;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    afc_pkg::location_t            loc_reg;
    afc_pkg::location_t            loc_next;
    logic                          any_out;
    logic                          all_in;

    afc_plane_regs u_plane_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    // pipeline advances unless a finished word is held
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (en && s_valid) begin
            lo_x_reg <= s_min_x;
            lo_y_reg <= s_min_y;
            lo_z_reg <= s_min_z;
            hi_x_reg <= s_max_x;
            hi_y_reg <= s_max_y;
            hi_z_reg <= s_max_z;
        end
    end

    for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++) begin : g_plane
        afc_plane_eval #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_plane_eval (
            .aclk  (aclk),
            .en    (en),
            .plane (planes[p]),
            .lo_x  (lo_x_reg),
            .lo_y  (lo_y_reg),
            .lo_z  (lo_z_reg),
            .hi_x  (hi_x_reg),
            .hi_y  (hi_y_reg),
            .hi_z  (hi_z_reg),
            .flags (flags[p])
        );
    end

    always_comb begin
        any_out = 1'b0;
        all_in  = 1'b1;
        for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
            any_out = any_out | flags[p].no_pos;
            all_in  = all_in & flags[p].all_pos;
        end
        priority if (any_out) begin
            loc_next = afc_pkg::LOC_OUTSIDE;
        end else if (all_in) begin
            loc_next = afc_pkg::LOC_INSIDE;
        end else begin
            loc_next = afc_pkg::LOC_PARTIAL;
        end
    end

    always_comb begin
        vld_next     = vld_reg;
        m_valid_next = m_valid_reg;
        if (en) begin
            vld_next     = {vld_reg[2:0], s_valid};
            m_valid_next = vld_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            loc_reg <= loc_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_location = loc_reg;

endmodule

// ----- hw/rtl/afc_plane_regs.sv -----
// ----------------------------------------------------------------------------
// afc_plane_regs
// Configuration storage for the six frustum planes.
// ----------------------------------------------------------------------------
module afc_plane_regs (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [afc_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [afc_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    output afc_pkg::plane_t                       planes [afc_pkg::NUM_PLANES]
);

    afc_pkg::plane_t planes_reg  [afc_pkg::NUM_PLANES];
    afc_pkg::plane_t planes_next [afc_pkg::NUM_PLANES];

    assign cfg_ready = 1'b1;

    always_comb begin
        planes_next = planes_reg;
        if (cfg_valid) begin
            unique case (afc_pkg::plane_index_t'(cfg_index))
                afc_pkg::REG_PLANE_RIGHT:  planes_next[afc_pkg::REG_PLANE_RIGHT]  = cfg_data;
                afc_pkg::REG_PLANE_LEFT:   planes_next[afc_pkg::REG_PLANE_LEFT]   = cfg_data;
                afc_pkg::REG_PLANE_BOTTOM: planes_next[afc_pkg::REG_PLANE_BOTTOM] = cfg_data;
                afc_pkg::REG_PLANE_TOP:    planes_next[afc_pkg::REG_PLANE_TOP]    = cfg_data;
                afc_pkg::REG_PLANE_FAR:    planes_next[afc_pkg::REG_PLANE_FAR]    = cfg_data;
                afc_pkg::REG_PLANE_NEAR:   planes_next[afc_pkg::REG_PLANE_NEAR]   = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < afc_pkg::NUM_PLANES; i++) begin
                planes_reg[i] <= '0;
            end
        end else begin
            planes_reg <= planes_next;
        end
    end

    assign planes = planes_reg;

endmodule

// ----- hw/rtl/afc_plane_eval.sv -----
// ----------------------------------------------------------------------------
// afc_plane_eval
// Three-stage test of the eight box corners against one plane.
// Stage 1: six products, stage 2: partial sums, stage 3: sign flags.
// ----------------------------------------------------------------------------
module afc_plane_eval #(
    parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  afc_pkg::plane_t               plane,
    input  logic signed [COORD_WIDTH-1:0] lo_x,
    input  logic signed [COORD_WIDTH-1:0] lo_y,
    input  logic signed [COORD_WIDTH-1:0] lo_z,
    input  logic signed [COORD_WIDTH-1:0] hi_x,
    input  logic signed [COORD_WIDTH-1:0] hi_y,
    input  logic signed [COORD_WIDTH-1:0] hi_z,
    output afc_pkg::plane_flags_t         flags
);

    localparam int PROD_W = afc_pkg::COEF_WIDTH + COORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;

    // index 0: min corner, 1: max corner
    logic signed [PROD_W-1:0]            px_reg [2];
    logic signed [PROD_W-1:0]            py_reg [2];
    logic signed [PROD_W-1:0]            pz_reg [2];
    logic signed [afc_pkg::COEF_WIDTH-1:0] d_reg;

    // xy index {x_sel, y_sel}, z index z_sel
    logic signed [SUM_W-1:0]             xy_reg [4];
    logic signed [SUM_W-1:0]             zd_reg [2];

    afc_pkg::plane_flags_t               flags_reg;
    afc_pkg::plane_flags_t               flags_next;
    logic [7:0]                          pos;
    logic signed [SUM_W-1:0]             dot;
    logic [2:0]                          corner;

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg[0] <= PROD_W'(plane.a) * PROD_W'(lo_x);
            px_reg[1] <= PROD_W'(plane.a) * PROD_W'(hi_x);
            py_reg[0] <= PROD_W'(plane.b) * PROD_W'(lo_y);
            py_reg[1] <= PROD_W'(plane.b) * PROD_W'(hi_y);
            pz_reg[0] <= PROD_W'(plane.c) * PROD_W'(lo_z);
            pz_reg[1] <= PROD_W'(plane.c) * PROD_W'(hi_z);
            d_reg     <= plane.d;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                xy_reg[i] <= SUM_W'(px_reg[i / 2]) + SUM_W'(py_reg[i % 2]);
            end
            for (int j = 0; j < 2; j++) begin
                zd_reg[j] <= SUM_W'(pz_reg[j]) + SUM_W'(d_reg);
            end
        end
    end

    always_comb begin
        pos    = '0;
        dot    = '0;
        corner = '0;
        for (int k = 0; k < 8; k++) begin
            corner = 3'(k);
            dot    = xy_reg[corner[2:1]] + zd_reg[corner[0]];
            pos[k] = !dot[SUM_W-1] && (|dot);
        end
        flags_next.no_pos  = ~|pos;
        flags_next.all_pos = &pos;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule
